FILE: src/swg_pkg.sv
// Shared types and constants for the swipe gesture detector.
package swg_pkg;

  localparam int DIST_BITS_DEF = 13;
  localparam int THR_W         = 13;
  localparam int TIMEOUT_W     = 16;
  localparam int CFG_W         = 16;
  localparam int STATUS_W      = 8;
  localparam int FLAG_W        = 12;
  localparam int GEST_W        = 3;

  localparam logic [THR_W-1:0]     THR_RESET     = 13'd200;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd1000;
  localparam logic [TIMEOUT_W-1:0] ELAPSED_MAX   = 16'hFFFF;

  typedef enum logic {
    REG_NEAR_THRESHOLD = 1'b0,
    REG_WINDOW_TIMEOUT = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    REQ_SAMPLE = 1'b0,
    REQ_TICK   = 1'b1
  } req_kind_t;

  typedef enum logic [GEST_W-1:0] {
    GEST_NONE = 3'd0,
    GEST_DU   = 3'd1,
    GEST_UD   = 3'd2,
    GEST_LR   = 3'd3,
    GEST_RL   = 3'd4
  } gesture_t;

  // Per-sensor proximity, bit 0 left, bit 1 center, bit 2 right.
  typedef struct packed {
    logic [2:0] near;
    logic [2:0] far;
  } sense_t;

  typedef struct packed {
    logic                 running;
    logic [TIMEOUT_W-1:0] elapsed;
    logic                 clear_flags;
  } win_state_t;

endpackage

FILE: src/swg_rules.sv
// Progress flag rules and gesture selection for one sensor sample.
module swg_rules (
  input  swg_pkg::sense_t                sense,
  input  logic [swg_pkg::FLAG_W-1:0]     flags,
  output logic [swg_pkg::FLAG_W-1:0]     flags_next,
  output swg_pkg::gesture_t              gesture
);

  localparam int L = 0;
  localparam int C = 1;
  localparam int R = 2;

  always_comb begin
    logic [swg_pkg::FLAG_W-1:0] f;
    logic [2:0] n;
    logic [2:0] fr;
    n  = sense.near;
    fr = sense.far;
    f  = flags;
    // Rules apply in order; each one sees the flags set by the ones above it.
    if (n[L] && !f[1] && !f[2] && fr[C] && fr[R]) f[0] = 1'b1;
    if (n[R] && !f[1] && f[0] && fr[C]) f[1] = 1'b1;
    if (n[C] && f[1] && f[0]) f[2] = 1'b1;

    if (n[C] && !f[4] && !f[5] && fr[L] && fr[R]) f[3] = 1'b1;
    if (n[R] && !f[5] && f[3] && fr[L]) f[4] = 1'b1;
    if (n[L] && f[4] && f[3]) f[5] = 1'b1;

    if (n[L] && !f[7] && !f[8] && fr[C] && fr[R]) f[6] = 1'b1;
    if (n[C] && !f[8] && f[6] && fr[R]) f[7] = 1'b1;
    if (n[R] && f[7] && f[6]) f[8] = 1'b1;

    if (n[R] && !f[10] && !f[11] && fr[C] && fr[L]) f[9] = 1'b1;
    if (n[C] && !f[11] && f[9] && fr[L]) f[10] = 1'b1;
    if (n[L] && f[10] && f[9]) f[11] = 1'b1;

    flags_next = f;
    if (&f[2:0]) begin
      gesture = swg_pkg::GEST_DU;
    end else if (&f[5:3]) begin
      gesture = swg_pkg::GEST_UD;
    end else if (&f[8:6]) begin
      gesture = swg_pkg::GEST_LR;
    end else if (&f[11:9]) begin
      gesture = swg_pkg::GEST_RL;
    end else begin
      gesture = swg_pkg::GEST_NONE;
    end
  end

endmodule

FILE: src/swg_window.sv
// Time window update for one tick request.
module swg_window (
  input  logic                            running,
  input  logic [swg_pkg::TIMEOUT_W-1:0]   elapsed,
  input  logic [swg_pkg::TIMEOUT_W-1:0]   timeout,
  output swg_pkg::win_state_t             win_next
);

  always_comb begin
    logic [swg_pkg::TIMEOUT_W-1:0] e;
    logic                          r;
    r = 1'b1;
    if (!running) begin
      e = '0;
    end else if (elapsed != swg_pkg::ELAPSED_MAX) begin
      e = elapsed + 1'b1;
    end else begin
      e = elapsed;
    end
    win_next.clear_flags = (e > timeout);
    if (win_next.clear_flags) begin
      r = 1'b0;
    end
    win_next.running = r;
    win_next.elapsed = e;
  end

endmodule

FILE: src/swipe_gesture_detector.sv
// Top level of the swipe gesture detector: input stage, state and result register.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+------------------------------------
//   in      | to block  | in_valid / in_ready | req_type, {left,center,right}_*
//   out     | from block| out_valid/out_ready | gesture
//   cfg     | to block  | cfg_we              | cfg_addr, cfg_wdata
//
// Each request is held in the input register and then moves to the result register,
// which holds its result. One request is taken every cycle unless a finished result
// waits untaken. The rate is set by the single pass through the flag rules,
// which reads and writes the progress flags in the same cycle. Reset clears the flags,
// the window and both valid bits and loads the register defaults. When the result is
// not taken, the input register holds one more request and then in_ready falls.
module swipe_gesture_detector #(
  parameter int DIST_BITS = swg_pkg::DIST_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           req_type,
  input  logic [DIST_BITS-1:0]           left_distance,
  input  logic [swg_pkg::STATUS_W-1:0]   left_status,
  input  logic [DIST_BITS-1:0]           center_distance,
  input  logic [swg_pkg::STATUS_W-1:0]   center_status,
  input  logic [DIST_BITS-1:0]           right_distance,
  input  logic [swg_pkg::STATUS_W-1:0]   right_status,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [swg_pkg::GEST_W-1:0]     gesture,
  input  logic                           cfg_we,
  input  logic                           cfg_addr,
  input  logic [swg_pkg::CFG_W-1:0]      cfg_wdata
);

  localparam int CMP_W = (DIST_BITS > swg_pkg::THR_W) ? DIST_BITS : swg_pkg::THR_W;

  logic [swg_pkg::THR_W-1:0]     near_threshold;
  logic [swg_pkg::TIMEOUT_W-1:0] window_timeout;
  logic [swg_pkg::FLAG_W-1:0]    progress_flags;
  logic [swg_pkg::TIMEOUT_W-1:0] window_elapsed;
  logic                          window_running;

  logic                          s1_valid;
  logic                          s1_tick;
  logic [DIST_BITS-1:0]          s1_dist [3];
  logic [swg_pkg::STATUS_W-1:0]  s1_status [3];

  logic                          advance;
  logic [CMP_W-1:0]              thr_ext;
  swg_pkg::sense_t               sense;
  logic [swg_pkg::FLAG_W-1:0]    flags_next;
  swg_pkg::gesture_t             rule_gesture;
  swg_pkg::win_state_t           win_next;

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;
  assign thr_ext  = CMP_W'(near_threshold);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sense.near[i] = (CMP_W'(s1_dist[i]) < thr_ext) && (s1_status[i] == '0);
      sense.far[i]  = (CMP_W'(s1_dist[i]) > thr_ext);
    end
  end

  swg_rules u_rules (
    .sense      (sense),
    .flags      (progress_flags),
    .flags_next (flags_next),
    .gesture    (rule_gesture)
  );

  swg_window u_window (
    .running  (window_running),
    .elapsed  (window_elapsed),
    .timeout  (window_timeout),
    .win_next (win_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      near_threshold <= swg_pkg::THR_RESET;
      window_timeout <= swg_pkg::TIMEOUT_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        swg_pkg::REG_NEAR_THRESHOLD: near_threshold <= cfg_wdata[swg_pkg::THR_W-1:0];
        swg_pkg::REG_WINDOW_TIMEOUT: window_timeout <= cfg_wdata[swg_pkg::TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      s1_tick      <= (req_type == swg_pkg::REQ_TICK);
      s1_dist[0]   <= left_distance;
      s1_dist[1]   <= center_distance;
      s1_dist[2]   <= right_distance;
      s1_status[0] <= left_status;
      s1_status[1] <= center_status;
      s1_status[2] <= right_status;
    end
  end

  // State update and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      progress_flags <= '0;
      window_elapsed <= '0;
      window_running <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        if (s1_tick) begin
          window_running <= win_next.running;
          window_elapsed <= win_next.elapsed;
          if (win_next.clear_flags) begin
            progress_flags <= '0;
          end
        end else begin
          progress_flags <= flags_next;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (advance) begin
      gesture <= s1_tick ? swg_pkg::GEST_NONE : rule_gesture;
    end
  end

endmodule

FILE: src/swg_checker.sv
// Port-level checks for the swipe gesture detector and their bind.
module swg_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [swg_pkg::GEST_W-1:0] gesture
);

  // A result code is always one of the five defined gestures.
  a_gesture_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (gesture <= swg_pkg::GEST_RL))
    else $error("gesture code out of range");

  // A stalled result keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(gesture))
    else $error("stalled result changed");

  // The block only pushes back on requests when a finished result waits.
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("request stalled while result side is free");

  // No result is shown in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind swipe_gesture_detector swg_checker u_swg_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .gesture   (gesture)
);
